// File: design/i2cms_pkg.sv
// Shared types for the I2C master byte sequencer: operation codes and the
// packed words carried on the command and result channels. No dependencies.
`default_nettype none

package i2cms_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_CHECK = 3'd5
  } op_e;

  localparam logic [7:0] PhaseTicksReset = 8'd15;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } out_word_t;

endpackage

`default_nettype wire

// File: design/i2c_master_byte_sequencer.sv
// I2C master byte sequencer. Every accepted input word is either a command
// (start, stop, write byte, read byte, check ack) or a tick that carries the
// sampled SDA level and advances the running command by one tick.
// Each command walks a fixed list of bus phases; each phase lasts phase_ticks
// ticks, set through the configuration write channel (reset value 15, always
// ready, write only while idle). A command that arrives while another runs
// is dropped. Every input word yields exactly one result word with the SCL
// and SDA drives (1 = released), busy, done, last read byte and ack sample.
// Throughput: one word per cycle while in_stall_o is low, set by the single
// pass through the phase logic into the result register. A two-entry output
// buffer (result register plus skid register) lets one more word in after an
// output stall begins; in_stall_o rises only once both entries are full.
// Reset releases both lines, clears all state and drops any buffered results.
// Depends on i2cms_pkg and i2cms_core.
`default_nettype none

module i2c_master_byte_sequencer (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  i2cms_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output i2cms_pkg::out_word_t out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [7:0]            cfg_data_i
);

  logic [7:0]           phase_ticks_q;
  logic                 accept;
  i2cms_pkg::out_word_t res;
  logic                 out_valid_q;
  i2cms_pkg::out_word_t out_q;
  logic                 skid_valid_q;
  i2cms_pkg::out_word_t skid_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cms_pkg::PhaseTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  i2cms_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .word_i        (in_data_i),
    .phase_ticks_i (phase_ticks_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      // output slot frees up: drain skid first, else take the new word
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (accept) out_q <= res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_stalled_accept_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && out_valid_q && out_stall_i |=> skid_valid_q)
    else $error("word accepted under stall was not buffered");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_stall_i |=> !skid_valid_q && out_valid_q)
    else $error("skid entry not moved to output");

endmodule

`default_nettype wire

// File: design/i2cms_core.sv
// Bus phase sequencer of the I2C master: command state, phase and tick
// counters, bit shifting and line drives. Uses i2cms_pkg.
`default_nettype none

module i2cms_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  i2cms_pkg::in_word_t  word_i,
  input  wire [7:0]            phase_ticks_i,
  output i2cms_pkg::out_word_t res_o
);

  localparam logic [4:0] ReadAckBase = 5'd25;

  i2cms_pkg::op_e cmd_q, cmd_d;
  logic [4:0] idx_q, idx_d;
  logic [7:0] tc_q, tc_d;
  logic [1:0] sub_q, sub_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       ackc_q, ackc_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic [7:0] rx_q, rx_d;
  logic       acks_q, acks_d;
  logic       done;

  logic [7:0] tc_inc;
  logic [4:0] next_idx;
  logic [1:0] sub_nx;
  logic [2:0] bit_nx;
  logic [4:0] ack_ofs;
  logic [4:0] total;
  i2cms_pkg::op_e op;

  assign tc_inc   = tc_q + 8'd1;
  assign next_idx = idx_q + 5'd1;
  assign sub_nx   = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
  assign bit_nx   = (sub_q == 2'd2) ? bit_q + 3'd1 : bit_q;
  assign ack_ofs  = next_idx - ReadAckBase;
  assign op       = i2cms_pkg::op_e'(word_i.operation);

  always_comb begin
    case (cmd_q)
      i2cms_pkg::OP_START: total = 5'd3;
      i2cms_pkg::OP_STOP:  total = 5'd4;
      i2cms_pkg::OP_WRITE: total = 5'd24;
      i2cms_pkg::OP_READ:  total = ackc_q ? 5'd29 : 5'd28;
      i2cms_pkg::OP_CHECK: total = 5'd3;
      default:             total = 5'd0;
    endcase
  end

  always_comb begin
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    tc_d    = tc_q;
    sub_d   = sub_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    ackc_d  = ackc_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rx_d    = rx_q;
    acks_d  = acks_q;
    done    = 1'b0;
    if (step_i) begin
      if (word_i.operation == i2cms_pkg::OP_TICK) begin
        if (cmd_q != i2cms_pkg::OP_TICK) begin
          tc_d = tc_inc;
          if (tc_inc >= phase_ticks_i) begin
            tc_d = 8'd0;
            // sample SDA at the end of an SCL-high phase
            if (cmd_q == i2cms_pkg::OP_READ && idx_q != 5'd0 && idx_q < ReadAckBase &&
                sub_q == 2'd1) begin
              shift_d = {shift_q[6:0], word_i.sda_in};
              if (bit_q == 3'd7) rx_d = {shift_q[6:0], word_i.sda_in};
            end else if (cmd_q == i2cms_pkg::OP_CHECK && idx_q == 5'd1) begin
              acks_d = word_i.sda_in;
            end
            idx_d = next_idx;
            sub_d = sub_nx;
            bit_d = bit_nx;
            if (next_idx >= total) begin
              cmd_d = i2cms_pkg::OP_TICK;
              idx_d = 5'd0;
              done  = 1'b1;
            end else begin
              case (cmd_q)
                i2cms_pkg::OP_START: begin
                  if (next_idx == 5'd1) sda_d = 1'b0;
                  else scl_d = 1'b0;
                end
                i2cms_pkg::OP_STOP: begin
                  if (next_idx == 5'd1) sda_d = 1'b0;
                  else if (next_idx == 5'd2) scl_d = 1'b1;
                  else sda_d = 1'b1;
                end
                i2cms_pkg::OP_WRITE: begin
                  if (sub_nx == 2'd0) begin
                    sda_d = shift_q[7];
                  end else if (sub_nx == 2'd1) begin
                    scl_d = 1'b1;
                  end else begin
                    scl_d   = 1'b0;
                    shift_d = {shift_q[6:0], 1'b0};
                    if (bit_nx == 3'd7) sda_d = 1'b1;
                  end
                end
                i2cms_pkg::OP_READ: begin
                  if (next_idx < ReadAckBase) begin
                    scl_d = (sub_nx == 2'd1);
                  end else if (ack_ofs == 5'd0) begin
                    sda_d = ~ackc_q;
                  end else if (ack_ofs == 5'd1) begin
                    scl_d = 1'b1;
                  end else if (ack_ofs == 5'd2) begin
                    scl_d = 1'b0;
                  end else begin
                    sda_d = 1'b1;
                  end
                end
                i2cms_pkg::OP_CHECK: begin
                  scl_d = (next_idx == 5'd1);
                end
                default: begin
                end
              endcase
            end
          end
        end
      end else if (word_i.operation <= i2cms_pkg::OP_CHECK &&
                   cmd_q == i2cms_pkg::OP_TICK) begin
        cmd_d = op;
        idx_d = 5'd0;
        tc_d  = 8'd0;
        sub_d = 2'd0;
        bit_d = 3'd0;
        case (op)
          i2cms_pkg::OP_START: begin
            scl_d = 1'b1;
            sda_d = 1'b1;
          end
          i2cms_pkg::OP_STOP: scl_d = 1'b0;
          i2cms_pkg::OP_WRITE: begin
            shift_d = word_i.tx_byte;
            sda_d   = word_i.tx_byte[7];
          end
          i2cms_pkg::OP_READ: begin
            // park the bit counters so phase one lands on bit zero, sub-phase zero
            shift_d = 8'd0;
            ackc_d  = word_i.send_ack;
            sda_d   = 1'b1;
            sub_d   = 2'd2;
            bit_d   = 3'd7;
          end
          i2cms_pkg::OP_CHECK: sda_d = 1'b1;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= i2cms_pkg::OP_TICK;
      idx_q   <= 5'd0;
      tc_q    <= 8'd0;
      sub_q   <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      ackc_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      rx_q    <= 8'd0;
      acks_q  <= 1'b0;
    end else begin
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      tc_q    <= tc_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      ackc_q  <= ackc_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rx_q    <= rx_d;
      acks_q  <= acks_d;
    end
  end

  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.busy_res  = (cmd_d != i2cms_pkg::OP_TICK);
    res_o.done_res  = done;
    res_o.rx_byte   = rx_d;
    res_o.ack_bit   = acks_d;
  end

  a_idle_idx_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == i2cms_pkg::OP_TICK |-> idx_q == 5'd0)
    else $error("phase index not cleared while idle");

  a_done_ends_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |-> cmd_q != i2cms_pkg::OP_TICK && !res_o.busy_res)
    else $error("done without a running command");

  a_rx_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rx_q) |-> $past(cmd_q) == i2cms_pkg::OP_READ && $past(step_i))
    else $error("received byte changed outside a read");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for i2c_master_byte_sequencer: sends command and tick words, predicts
// each result word with its own bus model and checks the result field by field.
// Depends on i2cms_pkg and the sequencer RTL.
module tb_top;

  localparam int CycleLimit = 600000;
  localparam int MaxPrints = 40;
  localparam int ReadAckPhase = 25;
  // directed rows before this one run at the reset phase length
  localparam int ResetTickRows = 6;
  localparam logic [2:0] OpUnusedLo = 3'd6;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  localparam i2cms_pkg::out_word_t IdleResult = '{scl_level: 1'b1, sda_level: 1'b1,
                                                  busy_res: 1'b0, done_res: 1'b0,
                                                  rx_byte: 8'h00, ack_bit: 1'b0};
  localparam i2cms_pkg::out_word_t StartResult = '{scl_level: 1'b1, sda_level: 1'b1,
                                                   busy_res: 1'b1, done_res: 1'b0,
                                                   rx_byte: 8'h00, ack_bit: 1'b0};

  typedef enum int {FILL_NONE, FILL_LOW, FILL_HIGH, FILL_RAND} fill_e;

  typedef struct {
    i2cms_pkg::in_word_t  word;
    fill_e                fill;
    bit                   typed;
    i2cms_pkg::out_word_t result;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  i2cms_pkg::in_word_t  in_data = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_stall;
  logic                 out_valid;
  logic                 cfg_ready;
  i2cms_pkg::out_word_t out_data;

  int                   cyc = 0;
  int                   err_count = 0;
  i2cms_pkg::out_word_t bus_expect_q[$];
  step_row_t            rows[$];

  // bus model state
  i2cms_pkg::op_e bus_cmd;
  logic [4:0]     bus_phase;
  logic [7:0]     bus_cnt;
  logic [7:0]     bus_shift;
  logic [7:0]     bus_rx;
  logic [7:0]     bus_ticks;
  logic           bus_ack_sel;
  logic           bus_scl;
  logic           bus_sda;
  logic           bus_ack;

  i2c_master_byte_sequencer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // no gaps on either side while cyc % 1000 is 800 or more
  function automatic bit take_break();
    if ((cyc % 1000) >= 800) return 1'b0;
    return $urandom_range(99) < 25;
  endfunction

  always @(posedge clk) begin
    out_stall <= take_break();
  end

  task automatic report_error(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    if (err_count <= MaxPrints)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_word(i2cms_pkg::out_word_t got, i2cms_pkg::out_word_t want);
    if (got.scl_level !== want.scl_level)
      report_error("scl_level", 8'(got.scl_level), 8'(want.scl_level));
    if (got.sda_level !== want.sda_level)
      report_error("sda_level", 8'(got.sda_level), 8'(want.sda_level));
    if (got.busy_res !== want.busy_res)
      report_error("busy_res", 8'(got.busy_res), 8'(want.busy_res));
    if (got.done_res !== want.done_res)
      report_error("done_res", 8'(got.done_res), 8'(want.done_res));
    if (got.rx_byte !== want.rx_byte)
      report_error("rx_byte", got.rx_byte, want.rx_byte);
    if (got.ack_bit !== want.ack_bit)
      report_error("ack_bit", 8'(got.ack_bit), 8'(want.ack_bit));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bus_expect_q.size() == 0) report_error("word with none pending", out_data.rx_byte, 8'h00);
      else check_word(out_data, bus_expect_q.pop_front());
    end
  end

  function automatic int phase_count(i2cms_pkg::op_e cmd);
    case (cmd)
      i2cms_pkg::OP_START: return 3;
      i2cms_pkg::OP_STOP:  return 4;
      i2cms_pkg::OP_WRITE: return 24;
      i2cms_pkg::OP_READ:  return bus_ack_sel ? 29 : 28;
      i2cms_pkg::OP_CHECK: return 3;
      default:             return 0;
    endcase
  endfunction

  // apply the drive change of a phase on entry
  function automatic void enter_phase(i2cms_pkg::op_e cmd, int idx);
    int sub;
    case (cmd)
      i2cms_pkg::OP_START: begin
        if (idx == 0) begin
          bus_sda = 1'b1;
          bus_scl = 1'b1;
        end else if (idx == 1) bus_sda = 1'b0;
        else bus_scl = 1'b0;
      end
      i2cms_pkg::OP_STOP: begin
        if (idx == 0) bus_scl = 1'b0;
        else if (idx == 1) bus_sda = 1'b0;
        else if (idx == 2) bus_scl = 1'b1;
        else bus_sda = 1'b1;
      end
      i2cms_pkg::OP_WRITE: begin
        sub = idx % 3;
        if (sub == 0) bus_sda = bus_shift[7];
        else if (sub == 1) bus_scl = 1'b1;
        else begin
          bus_scl = 1'b0;
          if (idx / 3 == 7) bus_sda = 1'b1;
          bus_shift = bus_shift << 1;
        end
      end
      i2cms_pkg::OP_READ: begin
        if (idx == 0) bus_sda = 1'b1;
        else if (idx < ReadAckPhase) bus_scl = ((idx - 1) % 3 == 1);
        else begin
          case (idx - ReadAckPhase)
            0: bus_sda = !bus_ack_sel;
            1: bus_scl = 1'b1;
            2: bus_scl = 1'b0;
            default: bus_sda = 1'b1;
          endcase
        end
      end
      i2cms_pkg::OP_CHECK: begin
        if (idx == 0) bus_sda = 1'b1;
        else if (idx == 1) bus_scl = 1'b1;
        else bus_scl = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void sample_at_end(i2cms_pkg::op_e cmd, int idx, logic sda);
    if (cmd == i2cms_pkg::OP_READ && idx >= 1 && idx < ReadAckPhase && (idx - 1) % 3 == 1) begin
      bus_shift = {bus_shift[6:0], sda};
      // publish only the whole byte
      if ((idx - 1) / 3 == 7) bus_rx = bus_shift;
    end else if (cmd == i2cms_pkg::OP_CHECK && idx == 1) begin
      bus_ack = sda;
    end
  endfunction

  function automatic i2cms_pkg::out_word_t predict_bus(i2cms_pkg::in_word_t w);
    i2cms_pkg::out_word_t r;
    logic                 done;
    i2cms_pkg::op_e       cmd;
    done = 1'b0;
    if (w.operation == i2cms_pkg::OP_TICK) begin
      if (bus_cmd != i2cms_pkg::OP_TICK) begin
        bus_cnt = bus_cnt + 8'd1;
        // compare after the increment, so zero acts as one
        if (bus_cnt >= bus_ticks) begin
          cmd = bus_cmd;
          bus_cnt = 8'h00;
          sample_at_end(cmd, int'(bus_phase), w.sda_in);
          bus_phase = bus_phase + 5'd1;
          if (bus_phase >= phase_count(cmd)) begin
            bus_cmd = i2cms_pkg::OP_TICK;
            bus_phase = 5'd0;
            done = 1'b1;
          end else begin
            enter_phase(cmd, int'(bus_phase));
          end
        end
      end
    end else if (w.operation <= i2cms_pkg::OP_CHECK && bus_cmd == i2cms_pkg::OP_TICK) begin
      bus_cmd = i2cms_pkg::op_e'(w.operation);
      bus_phase = 5'd0;
      bus_cnt = 8'h00;
      if (bus_cmd == i2cms_pkg::OP_WRITE) bus_shift = w.tx_byte;
      if (bus_cmd == i2cms_pkg::OP_READ) begin
        bus_shift = 8'h00;
        bus_ack_sel = w.send_ack;
      end
      enter_phase(bus_cmd, 0);
    end
    r.scl_level = bus_scl;
    r.sda_level = bus_sda;
    r.busy_res = (bus_cmd != i2cms_pkg::OP_TICK);
    r.done_res = done;
    r.rx_byte = bus_rx;
    r.ack_bit = bus_ack;
    return r;
  endfunction

  function automatic i2cms_pkg::in_word_t tick_word(logic sda);
    i2cms_pkg::in_word_t w;
    w.operation = i2cms_pkg::OP_TICK;
    w.tx_byte = 8'($urandom);
    w.send_ack = 1'($urandom);
    w.sda_in = sda;
    return w;
  endfunction

  task automatic send_word(i2cms_pkg::in_word_t w, bit typed, i2cms_pkg::out_word_t result);
    i2cms_pkg::out_word_t predicted;
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = predict_bus(w);
    bus_expect_q.push_back(typed ? result : predicted);
  endtask

  // tick until the running command finishes
  task automatic run_until_idle(fill_e fill);
    logic sda;
    while (bus_cmd != i2cms_pkg::OP_TICK) begin
      if (fill == FILL_LOW) sda = 1'b0;
      else if (fill == FILL_HIGH) sda = 1'b1;
      else sda = 1'($urandom_range(1));
      send_word(tick_word(sda), 1'b0, '0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ticks(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bus_ticks = value;
  endtask

  // mostly whole commands ticked through; some ticks while idle, spare codes
  // and commands dropped while busy as noise
  task automatic random_phase(int quota);
    int                  useful;
    int                  pick;
    i2cms_pkg::in_word_t w;
    useful = 0;
    while (useful < quota) begin
      w = tick_word(1'($urandom_range(1)));
      pick = $urandom_range(99);
      if (bus_cmd == i2cms_pkg::OP_TICK) begin
        if (pick < 80) begin
          w.operation = 3'($urandom_range(int'(i2cms_pkg::OP_CHECK), int'(i2cms_pkg::OP_START)));
          useful++;
        end else if (pick >= 90) begin
          w.operation = 3'($urandom_range(int'(OpUnusedHi), int'(OpUnusedLo)));
        end
      end else begin
        if (pick >= 94)
          w.operation = 3'($urandom_range(int'(OpUnusedHi), int'(i2cms_pkg::OP_START)));
        else useful++;
      end
      send_word(w, 1'b0, '0);
    end
    run_until_idle(FILL_RAND);
  endtask

  function automatic void add_row(logic [2:0] op, logic [7:0] tx, logic ack, logic sda,
                                  fill_e fill, bit typed, i2cms_pkg::out_word_t result);
    step_row_t row;
    row.word.operation = op;
    row.word.tx_byte = tx;
    row.word.send_ack = ack;
    row.word.sda_in = sda;
    row.fill = fill;
    row.typed = typed;
    row.result = result;
    rows.push_back(row);
  endfunction

  initial begin
    bus_cmd = i2cms_pkg::OP_TICK;
    bus_phase = 5'd0;
    bus_cnt = 8'h00;
    bus_shift = 8'h00;
    bus_rx = 8'h00;
    bus_ticks = i2cms_pkg::PhaseTicksReset;
    bus_ack_sel = 1'b0;
    bus_scl = 1'b1;
    bus_sda = 1'b1;
    bus_ack = 1'b0;

    add_row(i2cms_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, FILL_NONE, 1'b1, IdleResult);
    add_row(OpUnusedLo, 8'hFF, 1'b1, 1'b1, FILL_NONE, 1'b1, IdleResult);
    add_row(OpUnusedHi, 8'h00, 1'b0, 1'b0, FILL_NONE, 1'b1, IdleResult);
    add_row(i2cms_pkg::OP_START, 8'h00, 1'b0, 1'b0, FILL_NONE, 1'b1, StartResult);
    add_row(i2cms_pkg::OP_WRITE, 8'h5A, 1'b0, 1'b0, FILL_NONE, 1'b1, StartResult);
    add_row(OpUnusedHi, 8'hFF, 1'b1, 1'b1, FILL_RAND, 1'b0, '0);
    add_row(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0, FILL_RAND, 1'b0, '0);
    add_row(i2cms_pkg::OP_WRITE, 8'h00, 1'b1, 1'b1, FILL_RAND, 1'b0, '0);
    add_row(i2cms_pkg::OP_WRITE, 8'h80, 1'b0, 1'b0, FILL_RAND, 1'b0, '0);
    add_row(i2cms_pkg::OP_WRITE, 8'h01, 1'b0, 1'b0, FILL_RAND, 1'b0, '0);
    add_row(i2cms_pkg::OP_CHECK, 8'h00, 1'b0, 1'b0, FILL_LOW, 1'b0, '0);
    add_row(i2cms_pkg::OP_CHECK, 8'h00, 1'b0, 1'b0, FILL_HIGH, 1'b0, '0);
    add_row(i2cms_pkg::OP_READ, 8'h00, 1'b1, 1'b0, FILL_HIGH, 1'b0, '0);
    add_row(i2cms_pkg::OP_READ, 8'h00, 1'b0, 1'b0, FILL_LOW, 1'b0, '0);
    add_row(i2cms_pkg::OP_READ, 8'hA5, 1'b1, 1'b1, FILL_RAND, 1'b0, '0);
    add_row(i2cms_pkg::OP_STOP, 8'h00, 1'b0, 1'b0, FILL_RAND, 1'b0, '0);
    add_row(i2cms_pkg::OP_START, 8'h00, 1'b0, 1'b0, FILL_RAND, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      // shorten the phases once the reset length has been seen
      if (i == ResetTickRows) begin
        settle();
        write_ticks(8'd1);
      end
      send_word(rows[i].word, rows[i].typed, rows[i].result);
      if (rows[i].fill != FILL_NONE) run_until_idle(rows[i].fill);
    end
    settle();

    write_ticks(8'd1);
    random_phase(220);
    settle();
    write_ticks(8'd0);
    random_phase(100);
    settle();
    repeat (3) begin
      write_ticks(8'($urandom_range(6, 2)));
      random_phase(40);
      settle();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
